// ----- rtl/lif_neuron_refractory_step_assert.svh -----
// Assertion macros shared by the neuron step modules.
// Each one samples on the rising edge of clock and is off while reset is high.
`ifndef LIF_NEURON_REFRACTORY_STEP_ASSERT_SVH
`define LIF_NEURON_REFRACTORY_STEP_ASSERT_SVH

`define LNR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`define LNR_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/lnr_pkg.sv -----
package lnr_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned OFFSET_W    = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd26500000;
   localparam logic signed [DATA_W-1:0] REST_RESET      = -32'sd77400000;
   localparam logic signed [DATA_W-1:0] RESET_POT_RESET = 32'sd0;
   localparam logic [DATA_W-1:0]        LEAK_RESET      = 32'd20331516;
   localparam logic [DATA_W-1:0]        GAIN_RESET      = 32'd13958382;
   localparam logic [TICK_W-1:0]        TICKS_RESET     = 16'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_REST      = 3'd1,
      CSR_RESET_POT = 3'd2,
      CSR_LEAK      = 3'd3,
      CSR_GAIN      = 3'd4,
      CSR_TICKS     = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIFF,
      ST_MLO,
      ST_MHI,
      ST_ACC,
      ST_SUM,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] threshold;
      logic signed [DATA_W-1:0] rest_potential;
      logic signed [DATA_W-1:0] reset_potential;
      logic [DATA_W-1:0]        leak_factor;
      logic [DATA_W-1:0]        input_gain;
      logic [TICK_W-1:0]        refractory_ticks;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] current;
   } q_item_type;

   typedef struct packed {
      logic                     refractory;
      logic [OFFSET_W-1:0]      spike_frac;
      logic                     spike;
      logic signed [DATA_W-1:0] voltage_out;
   } rsp_type;

endpackage

// ----- rtl/lnr_front.sv -----
module lnr_front #(
   parameter int unsigned Depth = lnr_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lnr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output lnr_pkg::q_item_type              item,
   input  logic                             item_pop
);

   `include "lif_neuron_refractory_step_assert.svh"

   localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CNT_W = $clog2(Depth + 1);

   logic [lnr_pkg::DATA_W-1:0] slot_ff [Depth];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       push;
   logic                       pop;

   assign req_tready   = (count_ff != CNT_W'(Depth));
   assign push         = req_tvalid & req_tready;
   assign item.valid   = (count_ff != '0);
   assign item.current = slot_ff[rd_ptr_ff];
   assign pop          = item_pop & item.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_tdata[lnr_pkg::DATA_W-1:0];
      end
   end

   `LNR_ASSERT(a_count_bound, count_ff <= CNT_W'(Depth), "queue count beyond depth")
   `LNR_ASSERT(a_pop_nonempty, item_pop |-> count_ff != '0, "pop from empty queue")
   `LNR_ASSERT(a_no_push_full, count_ff == CNT_W'(Depth) |-> !push, "push into full queue")

endmodule

// ----- rtl/lnr_core.sv -----
module lnr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  lnr_pkg::cfg_type     cfg,
   input  lnr_pkg::q_item_type  item,
   output logic                 item_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lnr_pkg::rsp_type     rsp
);

   `include "lif_neuron_refractory_step_assert.svh"

   localparam int unsigned DW  = lnr_pkg::DATA_W;
   localparam int unsigned OW  = lnr_pkg::OFFSET_W;
   localparam int unsigned TW  = lnr_pkg::TICK_W;
   localparam int unsigned CW  = $clog2(OW);

   lnr_pkg::state_type     state_ff, state_in;
   logic signed [DW-1:0]   volt_ff, volt_in;
   logic signed [DW-1:0]   held_ff, held_in;
   logic [TW-1:0]          refr_left_ff, refr_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lnr_pkg::rsp_type       rsp_ff, rsp_in;

   logic signed [DW-1:0]   cur_in_ff, cur_in_in;
   logic signed [64:0]     prod_ff, prod_in;
   logic [49:0]            mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [56:0]            pp_ff, pp_in;
   logic [81:0]            acc_ff, acc_in;
   logic signed [DW-1:0]   vnew_ff, vnew_in;
   logic                   spike_ff, spike_in;
   logic                   refr_ff, refr_in;
   logic [DW:0]            rem_ff, rem_in;
   logic [DW-1:0]          den_ff, den_in;
   logic [OW-1:0]          quo_ff, quo_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   logic signed [64:0]     rnd_w;
   logic signed [49:0]     diff_w;
   logic [49:0]            delta_w;
   logic signed [50:0]     sum_w;
   logic signed [DW:0]     num_w;
   logic signed [DW:0]     dsub_w;
   logic [DW:0]            shift_w;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   assign rnd_w   = prod_ff + 65'sd32768;
   assign diff_w  = $signed({rnd_w[64], rnd_w[64:16]}) + 50'(cfg.rest_potential)
                    - 50'(volt_ff);
   assign delta_w = acc_ff[81:32];
   assign sum_w   = neg_ff ? 51'(volt_ff) - $signed({1'b0, delta_w})
                           : 51'(volt_ff) + $signed({1'b0, delta_w});
   assign num_w   = 33'(vnew_ff) - 33'(cfg.threshold);
   assign dsub_w  = 33'(vnew_ff) - 33'(volt_ff);
   assign shift_w = {rem_ff[DW-1:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      volt_in      = volt_ff;
      held_in      = held_ff;
      refr_left_in = refr_left_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_in       = rsp_ff;
      cur_in_in    = cur_in_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      vnew_in      = vnew_ff;
      spike_in     = spike_ff;
      refr_in      = refr_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      item_pop     = 1'b0;

      unique case (state_ff)
         lnr_pkg::ST_IDLE: begin
            if (item.valid) begin
               item_pop  = 1'b1;
               cur_in_in = item.current;
               spike_in  = 1'b0;
               quo_in    = '0;
               if (refr_left_ff != '0) begin
                  refr_in  = 1'b1;
                  vnew_in  = (refr_left_ff == TW'(1)) ? cfg.reset_potential : volt_ff;
                  state_in = lnr_pkg::ST_DONE;
               end else begin
                  refr_in  = 1'b0;
                  state_in = lnr_pkg::ST_PROD;
               end
            end
         end
         lnr_pkg::ST_PROD: begin
            prod_in  = held_ff * $signed({1'b0, cfg.input_gain});
            state_in = lnr_pkg::ST_DIFF;
         end
         lnr_pkg::ST_DIFF: begin
            neg_in   = diff_w[49];
            mag_in   = diff_w[49] ? 50'(-diff_w) : 50'(diff_w);
            state_in = lnr_pkg::ST_MLO;
         end
         lnr_pkg::ST_MLO: begin
            pp_in    = 57'(mag_ff[24:0]) * 57'(cfg.leak_factor);
            state_in = lnr_pkg::ST_MHI;
         end
         lnr_pkg::ST_MHI: begin
            acc_in   = 82'(pp_ff) + 82'h8000_0000;
            pp_in    = 57'(mag_ff[49:25]) * 57'(cfg.leak_factor);
            state_in = lnr_pkg::ST_ACC;
         end
         lnr_pkg::ST_ACC: begin
            acc_in   = acc_ff + {pp_ff, 25'b0};
            state_in = lnr_pkg::ST_SUM;
         end
         lnr_pkg::ST_SUM: begin
            if (sum_w[50:31] == '0 || sum_w[50:31] == '1) begin
               vnew_in = sum_w[DW-1:0];
            end else begin
               vnew_in = sum_w[50] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            end
            state_in = lnr_pkg::ST_CMP;
         end
         lnr_pkg::ST_CMP: begin
            state_in = lnr_pkg::ST_DONE;
            if (vnew_ff > cfg.threshold) begin
               spike_in = 1'b1;
               priority if (dsub_w[DW]) begin
                  quo_in = '0;
               end else if (dsub_w == '0 || num_w >= dsub_w) begin
                  quo_in = '1;
               end else begin
                  rem_in   = {1'b0, num_w[DW-1:0]};
                  den_in   = dsub_w[DW-1:0];
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = lnr_pkg::ST_DIV;
               end
            end
         end
         lnr_pkg::ST_DIV: begin
            if (shift_w >= {1'b0, den_ff}) begin
               rem_in = shift_w - {1'b0, den_ff};
               quo_in = {quo_ff[OW-2:0], 1'b1};
            end else begin
               rem_in = shift_w;
               quo_in = {quo_ff[OW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(OW - 1)) begin
               state_in = lnr_pkg::ST_DONE;
            end
         end
         lnr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.voltage_out = vnew_ff;
               rsp_in.spike       = spike_ff;
               rsp_in.spike_frac  = quo_ff;
               rsp_in.refractory  = refr_ff;
               volt_in            = vnew_ff;
               held_in            = cur_in_ff;
               if (refr_ff) begin
                  refr_left_in = refr_left_ff - TW'(1);
               end else if (spike_ff) begin
                  refr_left_in = cfg.refractory_ticks;
               end
               state_in = lnr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lnr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lnr_pkg::ST_IDLE;
         volt_ff      <= '0;
         held_ff      <= '0;
         refr_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         volt_ff      <= volt_in;
         held_ff      <= held_in;
         refr_left_ff <= refr_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      cur_in_ff <= cur_in_in;
      prod_ff   <= prod_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      vnew_ff   <= vnew_in;
      spike_ff  <= spike_in;
      refr_ff   <= refr_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
   end

   `LNR_ASSERT(a_refr_no_spike, rsp_valid_ff && rsp_ff.refractory |-> !rsp_ff.spike,
      "spike on refractory step")
   `LNR_ASSERT(a_quiet_offset, rsp_valid_ff && !rsp_ff.spike |-> rsp_ff.spike_frac == '0,
      "offset without spike")
   `LNR_ASSERT(a_rem_below_den, state_ff == lnr_pkg::ST_DIV |-> rem_ff < (DW+1)'(den_ff),
      "divider remainder out of range")
   `LNR_ASSERT_NEXT(a_div_ends, state_ff == lnr_pkg::ST_DIV && cnt_ff == CW'(OW - 1),
      state_ff == lnr_pkg::ST_DONE, "divider did not finish")

endmodule

// ----- rtl/lif_neuron_refractory_step.sv -----
// Leaky integrate-and-fire neuron, one request beat per time step.
// The req channel carries the injected current of a step; it drives the membrane
// on the following step. The rsp channel returns one beat per request with the
// new voltage, the spike flag, the sub-step spike offset and the refractory flag.
// The csr channel writes the six parameter registers by index and is always ready;
// an index past the last register is ignored. Write it only while the block is idle.
// Requests enter a small queue, so req_tready stays high until the queue is full.
// The sequencer takes one step at a time. After it takes the head of the queue, a
// refractory step goes straight to the result state, an integrating step passes the
// product, difference, low and high partial product, accumulate, sum and compare states,
// and a step that spikes then runs the restoring divider for the 16-bit offset. The
// next step starts right after the result register is loaded.
// Two partial products on one 25 by 32 bit multiplier form the leak update.
// A stalled rsp_tready holds the result beat in its output register; the sequencer
// then waits with the next finished step and the queue fills, after which
// req_tready drops. Synchronous reset restores the default parameters, clears
// voltage, held current and refractory count, and empties the queue.
module lif_neuron_refractory_step #(
   parameter int unsigned QueueDepth = lnr_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] input_current
   input  logic [lnr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] voltage_out, [32] spike, [48:33] spike_frac, [49] refractory
   output logic [lnr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lnr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lnr_pkg::DATA_W-1:0]        csr_data
);

   lnr_pkg::cfg_type     cfg_ff, cfg_in;
   lnr_pkg::q_item_type  item;
   logic                 item_pop;
   lnr_pkg::rsp_type     rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lnr_pkg::CSR_THRESHOLD: cfg_in.threshold        = csr_data;
            lnr_pkg::CSR_REST:      cfg_in.rest_potential   = csr_data;
            lnr_pkg::CSR_RESET_POT: cfg_in.reset_potential  = csr_data;
            lnr_pkg::CSR_LEAK:      cfg_in.leak_factor      = csr_data;
            lnr_pkg::CSR_GAIN:      cfg_in.input_gain       = csr_data;
            lnr_pkg::CSR_TICKS:     cfg_in.refractory_ticks = csr_data[lnr_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold        <= lnr_pkg::THRESHOLD_RESET;
         cfg_ff.rest_potential   <= lnr_pkg::REST_RESET;
         cfg_ff.reset_potential  <= lnr_pkg::RESET_POT_RESET;
         cfg_ff.leak_factor      <= lnr_pkg::LEAK_RESET;
         cfg_ff.input_gain       <= lnr_pkg::GAIN_RESET;
         cfg_ff.refractory_ticks <= lnr_pkg::TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lnr_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item       (item),
      .item_pop   (item_pop)
   );

   lnr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.refractory, rsp.spike_frac, rsp.spike, rsp.voltage_out};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import lnr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500_000;
   localparam int unsigned RANDOM_STEPS = 900;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned REPORT_LINES = 100;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {PROFILE_BIOLOGICAL, PROFILE_WIDE} profile_type;
   typedef enum int {ACCEPT_ALWAYS, ACCEPT_PATTERN, ACCEPT_SPARSE} sink_mode_type;

   class membrane_predictor;
      cfg_type cfg;
      logic signed [DATA_W-1:0] voltage;
      logic signed [DATA_W-1:0] held_current;
      logic [TICK_W-1:0] refractory_left;
      rsp_type expected_steps[$];
      int mismatches;
      int steps_checked;

      function new();
         cfg.threshold = THRESHOLD_RESET;
         cfg.rest_potential = REST_RESET;
         cfg.reset_potential = RESET_POT_RESET;
         cfg.leak_factor = LEAK_RESET;
         cfg.input_gain = GAIN_RESET;
         cfg.refractory_ticks = TICKS_RESET;
         voltage = '0;
         held_current = '0;
         refractory_left = '0;
         mismatches = 0;
         steps_checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] val);
         case (idx)
            CSR_THRESHOLD: cfg.threshold = val;
            CSR_REST: cfg.rest_potential = val;
            CSR_RESET_POT: cfg.reset_potential = val;
            CSR_LEAK: cfg.leak_factor = val;
            CSR_GAIN: cfg.input_gain = val;
            CSR_TICKS: cfg.refractory_ticks = val[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      // The current of a step is only latched here; the one latched on the
      // previous step drives the membrane.
      function void take_current(logic signed [DATA_W-1:0] current);
         rsp_type step;
         logic signed [95:0] product;
         logic signed [95:0] drive;
         logic signed [95:0] diff;
         logic signed [95:0] magnitude;
         logic signed [95:0] delta;
         logic signed [95:0] sum;
         logic signed [DATA_W-1:0] next_voltage;
         longint num;
         longint den;
         step = '0;
         next_voltage = voltage;
         if (refractory_left != 0) begin
            step.refractory = 1'b1;
            refractory_left = refractory_left - 1'b1;
            if (refractory_left == 0) next_voltage = $signed(cfg.reset_potential);
         end else begin
            product = 96'(held_current) * 96'($signed({1'b0, cfg.input_gain}));
            drive = (product + 96'sd32768) >>> 16;
            diff = drive + 96'($signed(cfg.rest_potential)) - 96'(voltage);
            magnitude = (diff < 0) ? -diff : diff;
            delta = (magnitude * 96'($signed({1'b0, cfg.leak_factor})) + 96'sd2147483648)
               >>> 32;
            if (diff < 0) delta = -delta;
            sum = 96'(voltage) + delta;
            if (sum > 96'sd2147483647) begin
               sum = 96'sd2147483647;
            end else if (sum < -96'sd2147483648) begin
               sum = -96'sd2147483648;
            end
            next_voltage = sum[DATA_W-1:0];
            if (next_voltage > $signed(cfg.threshold)) begin
               num = longint'(next_voltage) - longint'($signed(cfg.threshold));
               den = longint'(next_voltage) - longint'(voltage);
               step.spike = 1'b1;
               refractory_left = cfg.refractory_ticks;
               if (den < 0) begin
                  step.spike_frac = '0;
               end else if (den == 0 || num >= den) begin
                  step.spike_frac = '1;
               end else begin
                  step.spike_frac = OFFSET_W'((num <<< 16) / den);
               end
            end
         end
         voltage = next_voltage;
         held_current = current;
         step.voltage_out = next_voltage;
         expected_steps.push_back(step);
      endfunction

      task report(string what);
         if (mismatches < REPORT_LINES) $display("MISMATCH step %0d: %s", steps_checked, what);
         mismatches++;
      endtask

      task match_step(logic [RSP_TDATA_W-1:0] beat);
         rsp_type got;
         rsp_type want;
         got = beat[$bits(rsp_type)-1:0];
         if (expected_steps.size() == 0) begin
            report($sformatf("result beat %h with no step outstanding", beat));
            return;
         end
         want = expected_steps.pop_front();
         if (beat[RSP_TDATA_W-1:$bits(rsp_type)] != '0)
            report($sformatf("nonzero padding in beat %h", beat));
         if (got.voltage_out !== want.voltage_out)
            report($sformatf("voltage_out %0d, expected %0d", got.voltage_out,
               want.voltage_out));
         if (got.spike !== want.spike)
            report($sformatf("spike %b, expected %b", got.spike, want.spike));
         if (got.spike_frac !== want.spike_frac)
            report($sformatf("spike_frac %0d, expected %0d", got.spike_frac,
               want.spike_frac));
         if (got.refractory !== want.refractory)
            report($sformatf("refractory %b, expected %b", got.refractory, want.refractory));
         steps_checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   membrane_predictor tracker = new();
   int unsigned cycle_count = 0;
   int unsigned steps_sent = 0;
   int unsigned burst_left = 0;

   sink_mode_type sink_mode = ACCEPT_ALWAYS;
   int unsigned sink_span = 0;
   int unsigned sink_period = 1;
   int unsigned sink_duty = 1;
   int unsigned sink_phase = 0;

   logic [DATA_W-1:0] corner_currents[10] = '{
      32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h0000_0000, 32'h00F4_2400, 32'hFF0B_DC00, 32'h0001_0000
   };

   lif_neuron_refractory_step uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (sink_span == 0) begin
         sink_span = $urandom_range(300, 20);
         sink_mode = sink_mode_type'($urandom_range(2, 0));
         sink_period = $urandom_range(16, 2);
         sink_duty = $urandom_range(sink_period - 1, 1);
      end else begin
         sink_span--;
      end
      sink_phase = (sink_phase + 1) % sink_period;
      case (sink_mode)
         ACCEPT_ALWAYS: rsp_tready <= 1'b1;
         ACCEPT_PATTERN: rsp_tready <= (sink_phase < sink_duty);
         default: rsp_tready <= ($urandom_range(3, 0) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_step(rsp_tdata);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task send_current(logic [DATA_W-1:0] current);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(40, 1);
      end
      req_tvalid <= 1'b1;
      req_tdata <= current;
      do @(posedge clock); while (!req_tready);
      tracker.take_current(current);
      burst_left--;
      steps_sent++;
   endtask

   task drain_steps();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
   endtask

   task apply_config(cfg_type c);
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_SPARE_HI, $urandom);
      write_reg(CSR_THRESHOLD, c.threshold);
      write_reg(CSR_REST, c.rest_potential);
      write_reg(CSR_RESET_POT, c.reset_potential);
      write_reg(CSR_LEAK, c.leak_factor);
      write_reg(CSR_GAIN, c.input_gain);
      write_reg(CSR_TICKS, {16'($urandom), c.refractory_ticks});
      csr_valid <= 1'b0;
   endtask

   function cfg_type random_config(profile_type profile);
      cfg_type c;
      if (profile == PROFILE_WIDE) begin
         c.threshold = $urandom;
         c.rest_potential = $urandom;
         c.reset_potential = $urandom;
         c.leak_factor = $urandom;
         c.input_gain = $urandom;
         c.refractory_ticks = $urandom_range(30, 0);
      end else begin
         c.threshold = $urandom_range(50_000_000, 0) - 10_000_000;
         c.rest_potential = -$urandom_range(90_000_000, 50_000_000);
         c.reset_potential = -$urandom_range(80_000_000, 0);
         c.leak_factor = $urandom_range(32'h4000_0000, 32'h0100_0000);
         c.input_gain = $urandom_range(32'h0200_0000, 32'h0010_0000);
         c.refractory_ticks = $urandom_range(12, 0);
      end
      return c;
   endfunction

   function logic [DATA_W-1:0] random_current(profile_type profile);
      int unsigned pick;
      pick = $urandom_range(9, 0);
      if (profile == PROFILE_WIDE && pick < 7) return $urandom;
      if (pick < 7) return $urandom_range(8_000_000, 0) - 2_000_000;
      if (pick < 9) return $urandom;
      return $urandom_range(2000, 0) - 1000;
   endfunction

   initial begin
      cfg_type c;
      profile_type profile;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers: full-scale drive saturates, spikes, then counts down.
      send_current(32'h0000_0000);
      send_current(32'h7FFF_FFFF);
      send_current(32'h8000_0000);
      foreach (corner_currents[i]) send_current(corner_currents[i]);
      drain_steps();

      // Zero refractory time; rising above threshold and falling while above it.
      c = '{threshold: '0, rest_potential: '0, reset_potential: '0,
         leak_factor: 32'h1000_0000, input_gain: 32'h0001_0000, refractory_ticks: '0};
      apply_config(c);
      send_current(32'd16_000_000);
      send_current(32'd16_000_000);
      send_current(32'd16_000_000);
      send_current(-32'sd16_000_000);
      send_current(-32'sd16_000_000);
      drain_steps();

      // No leak: the voltage stays put above the lowest threshold.
      c.threshold = 32'h8000_0000;
      c.leak_factor = '0;
      apply_config(c);
      send_current(32'd5);
      send_current(32'd5);
      drain_steps();

      c = '{threshold: 32'h7FFF_FFFF, rest_potential: 32'h8000_0000,
         reset_potential: 32'h7FFF_FFFF, leak_factor: 32'hFFFF_FFFF,
         input_gain: 32'hFFFF_FFFF, refractory_ticks: '0};
      apply_config(c);
      send_current(32'h8000_0000);
      send_current(32'h8000_0000);
      send_current(32'h7FFF_FFFF);
      send_current(32'h7FFF_FFFF);
      drain_steps();

      steps_sent = 0;
      while (steps_sent < RANDOM_STEPS) begin
         profile = ($urandom_range(3, 0) == 0) ? PROFILE_WIDE : PROFILE_BIOLOGICAL;
         apply_config(random_config(profile));
         repeat ($urandom_range(120, 40)) send_current(random_current(profile));
         drain_steps();
      end

      // Longest refractory count, loaded by a strong drive.
      c = random_config(PROFILE_BIOLOGICAL);
      c.leak_factor = 32'h8000_0000;
      c.refractory_ticks = 16'hFFFF;
      apply_config(c);
      send_current(32'h7FFF_FFFF);
      send_current(32'h7FFF_FFFF);
      repeat (30) send_current(random_current(PROFILE_BIOLOGICAL));
      drain_steps();

      if (tracker.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
